// File: hw/rtl/bleads_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bleads_pkg;

	localparam logic [7:0] MAX_PAYLOAD_BYTES = 8'd255;
	localparam logic [7:0] POSITION_LIMIT    = 8'hFF;

	localparam logic [7:0] KIND_MANUFACTURER = 8'hFF;
	localparam logic [7:0] KIND_SERVICE      = 8'h16;

	localparam logic [1:0] MODE_AD_KIND      = 2'd0;
	localparam logic [1:0] MODE_MANUFACTURER = 2'd1;
	localparam logic [1:0] MODE_SERVICE      = 2'd2;

	localparam logic [1:0] CFG_SEARCH_MODE    = 2'd0;
	localparam logic [1:0] CFG_SEARCH_AD_KIND = 2'd1;
	localparam logic [1:0] CFG_SEARCH_ID      = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  ad_kind;
		logic [15:0] id;
	} cfg_t;

	typedef struct packed {
		logic       found;
		logic [7:0] data_offset;
		logic [7:0] data_length;
	} result_t;

endpackage

`default_nettype wire

// File: hw/rtl/bleads_scan_core.sv
`timescale 1ns / 1ps
`default_nettype none

module bleads_scan_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire bleads_pkg::cfg_t     cfg,
	input  wire logic                 step_en,
	input  wire logic [7:0]           byte_in,
	input  wire logic                 last_in,
	output bleads_pkg::result_t       result
);

	typedef enum logic [1:0] {
		PH_LENGTH  = 2'd0,
		PH_TYPE    = 2'd1,
		PH_BODY    = 2'd2,
		PH_STOPPED = 2'd3
	} phase_t;

	phase_t     phase_q, phase_n;
	logic [7:0] pos_q, pos_n;
	logic [7:0] start_q, start_n;
	logic [7:0] len_q, len_n;
	logic [7:0] rem_q, rem_n;
	logic [7:0] idlo_q, idlo_n;
	logic       cand_q, cand_n;
	logic       locked_q, locked_n;
	logic [7:0] moff_q, moff_n;
	logic [7:0] mlen_q, mlen_n;
	logic       done;
	logic       cand_fin;
	logic [7:0] k;

	always_comb begin
		phase_n  = phase_q;
		start_n  = start_q;
		len_n    = len_q;
		rem_n    = rem_q;
		idlo_n   = idlo_q;
		cand_n   = cand_q;
		locked_n = locked_q;
		moff_n   = moff_q;
		mlen_n   = mlen_q;
		done     = 1'b0;
		cand_fin = cand_q;
		k        = pos_q - start_q;

		if (pos_q < bleads_pkg::MAX_PAYLOAD_BYTES && phase_q != PH_STOPPED) begin
			case (phase_q)
				PH_LENGTH: begin
					if (byte_in == 8'd0) begin
						phase_n = PH_STOPPED;
					end else begin
						start_n = pos_q;
						len_n   = byte_in;
						rem_n   = byte_in;
						cand_n  = 1'b0;
						phase_n = PH_TYPE;
					end
				end
				PH_TYPE: begin
					rem_n = rem_q - 8'd1;
					case (cfg.mode)
						bleads_pkg::MODE_AD_KIND: begin
							cand_fin = (byte_in == cfg.ad_kind);
						end
						bleads_pkg::MODE_MANUFACTURER: begin
							cand_fin = (byte_in == bleads_pkg::KIND_MANUFACTURER) &&
								(len_q >= 8'd3);
						end
						bleads_pkg::MODE_SERVICE: begin
							cand_fin = (byte_in == bleads_pkg::KIND_SERVICE) &&
								(len_q >= 8'd3);
						end
						default: begin
							cand_fin = 1'b0;
						end
					endcase
					cand_n = cand_fin;
					if (rem_n == 8'd0) begin
						done = 1'b1;
					end else begin
						phase_n = PH_BODY;
					end
				end
				PH_BODY: begin
					rem_n = rem_q - 8'd1;
					if (k == 8'd2) begin
						idlo_n = byte_in;
					end else if (k == 8'd3 && (cfg.mode == bleads_pkg::MODE_MANUFACTURER ||
						cfg.mode == bleads_pkg::MODE_SERVICE)) begin
						cand_fin = cand_q && ({byte_in, idlo_q} == cfg.id);
					end
					cand_n = cand_fin;
					if (rem_n == 8'd0) begin
						done = 1'b1;
					end
				end
				default: begin
				end
			endcase

			if (done) begin
				if (cand_fin && !locked_q) begin
					if (cfg.mode == bleads_pkg::MODE_MANUFACTURER) begin
						moff_n = start_q + 8'd4;
						mlen_n = len_q - 8'd3;
					end else begin
						moff_n = start_q + 8'd2;
						mlen_n = len_q - 8'd1;
					end
					locked_n = 1'b1;
					phase_n  = PH_STOPPED;
				end else begin
					phase_n = PH_LENGTH;
				end
				cand_n = 1'b0;
			end
		end

		pos_n = (pos_q == bleads_pkg::POSITION_LIMIT) ? pos_q : pos_q + 8'd1;

		result.found       = locked_n;
		result.data_offset = locked_n ? moff_n : 8'd0;
		result.data_length = locked_n ? mlen_n : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LENGTH;
			pos_q    <= 8'd0;
			start_q  <= 8'd0;
			len_q    <= 8'd0;
			rem_q    <= 8'd0;
			idlo_q   <= 8'd0;
			cand_q   <= 1'b0;
			locked_q <= 1'b0;
			moff_q   <= 8'd0;
			mlen_q   <= 8'd0;
		end else if (step_en) begin
			if (last_in) begin
				phase_q  <= PH_LENGTH;
				pos_q    <= 8'd0;
				start_q  <= 8'd0;
				len_q    <= 8'd0;
				rem_q    <= 8'd0;
				idlo_q   <= 8'd0;
				cand_q   <= 1'b0;
				locked_q <= 1'b0;
				moff_q   <= 8'd0;
				mlen_q   <= 8'd0;
			end else begin
				phase_q  <= phase_n;
				pos_q    <= pos_n;
				start_q  <= start_n;
				len_q    <= len_n;
				rem_q    <= rem_n;
				idlo_q   <= idlo_n;
				cand_q   <= cand_n;
				locked_q <= locked_n;
				moff_q   <= moff_n;
				mlen_q   <= mlen_n;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		locked_q |-> phase_q == PH_STOPPED)
		else $error("Match is locked while the scan is still running.");

	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LENGTH |-> !cand_q)
		else $error("Candidate flag survives into a new structure.");

	assert property (@(posedge clk) disable iff (!arst_n)
		step_en && last_in |=> pos_q == 8'd0 && !locked_q)
		else $error("Scan state was not cleared after the last byte of a payload.");

endmodule

`default_nettype wire

// File: hw/rtl/ble_ad_structure_scanner.sv
// Result path: the last payload byte is accepted into the input register, and the scan update of
// the input register goes straight into the result register once that register is free.
// Throughput: one payload byte per cycle unless stalled as below; the scan state steps once per byte.
// A waiting result stalls only the final byte of the next payload, not the bytes before it.
// Reset (arst_n low, asynchronous) clears the config registers, the scan state and both stage valid flags.
`timescale 1ns / 1ps
`default_nettype none

module ble_ad_structure_scanner (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // payload_byte
	input  wire logic        s_axis_tlast,   // end_of_payload
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // data_offset, data_length
	output logic [0:0]       m_axis_tuser    // found
);

	bleads_pkg::cfg_t    cfg_q;
	bleads_pkg::result_t res_comb;
	bleads_pkg::result_t res_q;
	logic [7:0]          byte_s1;
	logic                last_s1;
	logic                valid_s1;
	logic                out_free;
	logic                advance;
	logic                m_valid_q;

	assign out_free      = !m_valid_q || m_axis_tready;
	assign advance       = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bleads_pkg::CFG_SEARCH_MODE:    cfg_q.mode    <= cfg_wdata[1:0];
				bleads_pkg::CFG_SEARCH_AD_KIND: cfg_q.ad_kind <= cfg_wdata[7:0];
				bleads_pkg::CFG_SEARCH_ID:      cfg_q.id      <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	bleads_scan_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.step_en (advance),
		.byte_in (byte_s1),
		.last_in (last_s1),
		.result  (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_q <= res_comb;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {res_q.data_length, res_q.data_offset};
	assign m_axis_tuser  = res_q.found;

endmodule

`default_nettype wire
